// File: rtl/core/phfc_pkg.sv
// package for the password hash format checker
// holds the item types, the form lengths and the pbkdf2 prefix text
// no dependencies
package phfc_pkg;

    // fixed lengths of the two forms
    localparam logic [6:0] BCRYPT_LENGTH    = 7'd60;
    localparam logic [6:0] SALT_HEX_CHARS   = 7'd32;
    localparam logic [6:0] DIGEST_HEX_CHARS = 7'd64;
    localparam logic [6:0] PREFIX_LENGTH    = 7'd7;

    // format kind codes
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BCRYPT = 2'd1;
    localparam logic [1:0] KIND_PBKDF2 = 2'd2;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_P  = 8'h70;
    localparam logic [7:0] CH_LOW_Y  = 8'h79;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;

    // one input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_string;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic       hash_valid;
        logic [1:0] format_kind;
    } out_item_t;

    // expected character at each place of the "pbkdf2$" prefix
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h62;
            3'd2:    ch = 8'h6b;
            3'd3:    ch = 8'h64;
            3'd4:    ch = 8'h66;
            3'd5:    ch = 8'h32;
            default: ch = CH_DOLLAR;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/password_hash_format_check.sv
// top level of the password hash format checker
// parses a stored-password string one character per item, uses phfc_pkg
// depends on phfc_pkg only
//
// usage:
//   s_ channel: one character per item (char_code, last_char, empty_string)
//   m_ channel: one result item (hash_valid, format_kind) for each item
//   with last_char or empty_string set, none for other characters
//   throughput: one item per cycle while s_ready is high; the parse state is updated in the
//   same cycle as the item is taken, so the next character follows at once
//   result: shown in the cycle after its last character is accepted, from the
//   output register, when that is empty or being taken; else held in the skid register
//   stall: a two-entry output stage (output register and skid register)
//   keeps taking items while a result waits; s_ready drops only when both
//   hold a result, and characters that give no result then wait too
//   reset: aresetn, synchronous, active low; the parse returns to the
//   start of a string and both output entries are emptied
module password_hash_format_check (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  phfc_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output phfc_pkg::out_item_t  m_data
);

    typedef enum logic [3:0] {
        PH_START,
        PH_BCRYPT,
        PH_PREFIX,
        PH_ITER,
        PH_SALT,
        PH_DIGEST,
        PH_FAIL
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [6:0]          pos_reg, pos_next;
    logic                digits_reg, digits_next;
    logic                m_valid_reg, m_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    phfc_pkg::out_item_t m_data_reg, m_data_next;
    phfc_pkg::out_item_t skid_data_reg, skid_data_next;

    logic                accept;
    logic                take;
    logic                produce;
    phfc_pkg::out_item_t result;
    logic [7:0]          ch;
    logic                is_digit, is_letter, is_low_hex;

    assign accept  = s_valid && s_ready;
    assign take    = m_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign produce = accept && (s_data.last_char || s_data.empty_string);

    // character classes
    assign ch        = s_data.char_code;
    assign is_digit  = (ch >= phfc_pkg::CH_ZERO) && (ch <= phfc_pkg::CH_NINE);
    assign is_letter = ((ch >= phfc_pkg::CH_LOW_A) && (ch <= phfc_pkg::CH_LOW_Z))
                    || ((ch >= phfc_pkg::CH_UP_A) && (ch <= phfc_pkg::CH_UP_Z));
    assign is_low_hex = is_digit
                     || ((ch >= phfc_pkg::CH_LOW_A) && (ch <= phfc_pkg::CH_LOW_F));

    // parse step for one character, end-of-string check and result
    always_comb begin
        phase_t     ph;
        logic [6:0] pos;
        logic       dig;
        logic       ok;
        ph     = phase_reg;
        pos    = pos_reg;
        dig    = digits_reg;
        ok     = 1'b0;
        result = '{hash_valid: 1'b0, format_kind: phfc_pkg::KIND_NONE};

        unique case (phase_reg)
            PH_START: begin
                if (ch == phfc_pkg::CH_DOLLAR) begin
                    ph  = PH_BCRYPT;
                    pos = 7'd1;
                    ok  = 1'b1;
                end else if (ch == phfc_pkg::CH_LOW_P) begin
                    ph  = PH_PREFIX;
                    pos = 7'd1;
                    ok  = 1'b1;
                end
            end
            PH_BCRYPT: begin
                if (pos_reg < phfc_pkg::BCRYPT_LENGTH) begin
                    if (pos_reg == 7'd1) begin
                        ok = (ch == phfc_pkg::CH_TWO);
                    end else if (pos_reg == 7'd2) begin
                        ok = (ch == phfc_pkg::CH_LOW_A) || (ch == phfc_pkg::CH_LOW_B)
                          || (ch == phfc_pkg::CH_LOW_Y);
                    end else if (pos_reg == 7'd3 || pos_reg == 7'd6) begin
                        ok = (ch == phfc_pkg::CH_DOLLAR);
                    end else if (pos_reg == 7'd4 || pos_reg == 7'd5) begin
                        ok = is_digit;
                    end else begin
                        ok = is_letter || is_digit || (ch == phfc_pkg::CH_DOT)
                          || (ch == phfc_pkg::CH_SLASH);
                    end
                    pos = pos_reg + 7'd1;
                end
            end
            PH_PREFIX: begin
                if (pos_reg < phfc_pkg::PREFIX_LENGTH
                    && ch == phfc_pkg::prefix_char(pos_reg[2:0])) begin
                    ok  = 1'b1;
                    pos = pos_reg + 7'd1;
                    if (pos == phfc_pkg::PREFIX_LENGTH) begin
                        ph  = PH_ITER;
                        pos = 7'd0;
                        dig = 1'b0;
                    end
                end
            end
            PH_ITER: begin
                if (is_digit) begin
                    dig = 1'b1;
                    ok  = 1'b1;
                end else if (ch == phfc_pkg::CH_DOLLAR && digits_reg) begin
                    ph  = PH_SALT;
                    pos = 7'd0;
                    ok  = 1'b1;
                end
            end
            PH_SALT: begin
                if (is_low_hex && pos_reg < phfc_pkg::SALT_HEX_CHARS) begin
                    pos = pos_reg + 7'd1;
                    ok  = 1'b1;
                end else if (ch == phfc_pkg::CH_DOLLAR
                             && pos_reg == phfc_pkg::SALT_HEX_CHARS) begin
                    ph  = PH_DIGEST;
                    pos = 7'd0;
                    ok  = 1'b1;
                end
            end
            PH_DIGEST: begin
                if (is_low_hex && pos_reg < phfc_pkg::DIGEST_HEX_CHARS) begin
                    pos = pos_reg + 7'd1;
                    ok  = 1'b1;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        if (!ok) begin
            ph  = PH_FAIL;
            pos = 7'd0;
        end

        // completed form at the last character
        if (ph == PH_BCRYPT && pos == phfc_pkg::BCRYPT_LENGTH) begin
            result = '{hash_valid: 1'b1, format_kind: phfc_pkg::KIND_BCRYPT};
        end else if (ph == PH_DIGEST && pos == phfc_pkg::DIGEST_HEX_CHARS) begin
            result = '{hash_valid: 1'b1, format_kind: phfc_pkg::KIND_PBKDF2};
        end

        // empty string gives not-valid and drops any partial string
        if (s_data.empty_string) begin
            result = '{hash_valid: 1'b0, format_kind: phfc_pkg::KIND_NONE};
        end

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        digits_next = digits_reg;
        if (accept) begin
            if (s_data.empty_string || s_data.last_char) begin
                phase_next  = PH_START;
                pos_next    = 7'd0;
                digits_next = 1'b0;
            end else begin
                phase_next  = ph;
                pos_next    = pos;
                digits_next = dig;
            end
        end
    end

    // output register and skid register
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (produce) begin
            if (!m_valid_reg || take) begin
                m_valid_next = 1'b1;
                m_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (take) begin
            if (skid_valid_reg) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            pos_reg        <= 7'd0;
            digits_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            digits_reg     <= digits_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds an item with output register empty");

    // a valid hash always carries a form, a failed one never does
    a_kind_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.hash_valid
                         == (m_data_reg.format_kind != phfc_pkg::KIND_NONE)))
        else $error("format kind disagrees with hash valid");

    // each string end returns the parse to its start
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.last_char || s_data.empty_string))
        |=> (phase_reg == PH_START && pos_reg == 7'd0 && !digits_reg))
        else $error("parse state not cleared after end of string");

    // failed phase keeps no position
    a_fail_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FAIL) |-> (pos_reg == 7'd0))
        else $error("failed phase with non-zero position");
`endif

endmodule

// File: tb/tb_password_hash_format_check.sv
// testbench for password_hash_format_check: streams stored-password strings
// and checks each verdict against a cycle-free predictor of the parser
// depends on phfc_pkg and the password_hash_format_check rtl
module tb_password_hash_format_check;
    timeunit 1ns;
    timeprecision 1ps;

    // parse phases of the predictor
    typedef enum logic [2:0] {
        SCAN_START, SCAN_BCRYPT, SCAN_PREFIX, SCAN_ITER, SCAN_SALT, SCAN_DIGEST, SCAN_FAIL
    } scan_phase_t;

    // "pbkdf2$", 'k' and 'd' have no package constant
    localparam logic [7:0] PBKDF2_TAG [0:6] = '{
        phfc_pkg::CH_LOW_P, phfc_pkg::CH_LOW_B, 8'h6b, 8'h64,
        phfc_pkg::CH_LOW_F, phfc_pkg::CH_TWO, phfc_pkg::CH_DOLLAR
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    phfc_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    phfc_pkg::out_item_t m_data;

    // predictor state
    scan_phase_t scan_phase;
    logic [6:0]  scan_pos;
    logic        iter_seen;

    phfc_pkg::out_item_t verdict_q[$];
    phfc_pkg::out_item_t want;
    logic [7:0]          text_q[$];
    int                  mismatch_count;
    int                  sent_chars;
    int                  sent_results;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  stall_cycles;

    password_hash_format_check dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // character classes
    function automatic bit is_dec(input logic [7:0] c);
        return c >= phfc_pkg::CH_ZERO && c <= phfc_pkg::CH_NINE;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= phfc_pkg::CH_LOW_A && c <= phfc_pkg::CH_LOW_Z)
            || (c >= phfc_pkg::CH_UP_A && c <= phfc_pkg::CH_UP_Z);
    endfunction

    function automatic bit is_low_hex(input logic [7:0] c);
        return is_dec(c) || (c >= phfc_pkg::CH_LOW_A && c <= phfc_pkg::CH_LOW_F);
    endfunction

    function automatic void clear_scan();
        scan_phase = SCAN_START;
        scan_pos   = '0;
        iter_seen  = 1'b0;
    endfunction

    // advance the parse by one item, returns 1 when a verdict is due
    function automatic bit predict_verdict(input phfc_pkg::in_item_t it,
                                           output phfc_pkg::out_item_t res);
        logic [7:0] c;
        logic [6:0] pos;
        bit         ok;
        c   = it.char_code;
        pos = scan_pos;
        ok  = 1'b0;
        res = '{hash_valid: 1'b0, format_kind: phfc_pkg::KIND_NONE};
        if (it.empty_string) begin
            clear_scan();
            return 1'b1;
        end
        case (scan_phase)
            SCAN_START: begin
                if (c == phfc_pkg::CH_DOLLAR) begin
                    scan_phase = SCAN_BCRYPT;
                    pos = 7'd1;
                    ok = 1'b1;
                end else if (c == phfc_pkg::CH_LOW_P) begin
                    scan_phase = SCAN_PREFIX;
                    pos = 7'd1;
                    ok = 1'b1;
                end
            end
            SCAN_BCRYPT: begin
                if (pos < phfc_pkg::BCRYPT_LENGTH) begin
                    if (pos == 7'd1) ok = (c == phfc_pkg::CH_TWO);
                    else if (pos == 7'd2) ok = (c == phfc_pkg::CH_LOW_A
                                                || c == phfc_pkg::CH_LOW_B
                                                || c == phfc_pkg::CH_LOW_Y);
                    else if (pos == 7'd3 || pos == 7'd6) ok = (c == phfc_pkg::CH_DOLLAR);
                    else if (pos == 7'd4 || pos == 7'd5) ok = is_dec(c);
                    else ok = is_alpha(c) || is_dec(c) || c == phfc_pkg::CH_DOT
                              || c == phfc_pkg::CH_SLASH;
                    pos = pos + 7'd1;
                end
            end
            SCAN_PREFIX: begin
                if (pos < phfc_pkg::PREFIX_LENGTH && c == PBKDF2_TAG[pos[2:0]]) begin
                    ok = 1'b1;
                    pos = pos + 7'd1;
                    if (pos == phfc_pkg::PREFIX_LENGTH) begin
                        scan_phase = SCAN_ITER;
                        pos = '0;
                        iter_seen = 1'b0;
                    end
                end
            end
            SCAN_ITER: begin
                if (is_dec(c)) begin
                    iter_seen = 1'b1;
                    ok = 1'b1;
                end else if (c == phfc_pkg::CH_DOLLAR && iter_seen) begin
                    scan_phase = SCAN_SALT;
                    pos = '0;
                    ok = 1'b1;
                end
            end
            SCAN_SALT: begin
                if (is_low_hex(c) && pos < phfc_pkg::SALT_HEX_CHARS) begin
                    pos = pos + 7'd1;
                    ok = 1'b1;
                end else if (c == phfc_pkg::CH_DOLLAR && pos == phfc_pkg::SALT_HEX_CHARS) begin
                    scan_phase = SCAN_DIGEST;
                    pos = '0;
                    ok = 1'b1;
                end
            end
            SCAN_DIGEST: begin
                if (is_low_hex(c) && pos < phfc_pkg::DIGEST_HEX_CHARS) begin
                    pos = pos + 7'd1;
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (!ok) begin
            scan_phase = SCAN_FAIL;
            pos = '0;
        end
        scan_pos = pos;
        if (!it.last_char) return 1'b0;
        if (scan_phase == SCAN_BCRYPT && scan_pos == phfc_pkg::BCRYPT_LENGTH)
            res = '{hash_valid: 1'b1, format_kind: phfc_pkg::KIND_BCRYPT};
        else if (scan_phase == SCAN_DIGEST && scan_pos == phfc_pkg::DIGEST_HEX_CHARS)
            res = '{hash_valid: 1'b1, format_kind: phfc_pkg::KIND_PBKDF2};
        clear_scan();
        return 1'b1;
    endfunction

    // random characters of the various classes
    function automatic logic [7:0] rand_digit();
        return phfc_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(15);
        return (v < 10) ? phfc_pkg::CH_ZERO + 8'(v) : phfc_pkg::CH_LOW_A + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rand_body();
        int v;
        v = $urandom_range(63);
        if (v == 0) return phfc_pkg::CH_DOT;
        if (v == 1) return phfc_pkg::CH_SLASH;
        if (v < 28) return phfc_pkg::CH_UP_A + 8'(v - 2);
        if (v < 54) return phfc_pkg::CH_LOW_A + 8'(v - 28);
        return phfc_pkg::CH_ZERO + 8'(v - 54);
    endfunction

    // add one character at the end of the string being built
    function automatic void append_char(input logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    // string builders, appending to text_q
    function automatic void put_bcrypt(input logic [7:0] variant, input int body_len);
        append_char(phfc_pkg::CH_DOLLAR);
        append_char(phfc_pkg::CH_TWO);
        append_char(variant);
        append_char(phfc_pkg::CH_DOLLAR);
        append_char(rand_digit());
        append_char(rand_digit());
        append_char(phfc_pkg::CH_DOLLAR);
        repeat (body_len) append_char(rand_body());
    endfunction

    function automatic void put_pbkdf2(input int iters, input int salt_n, input int digest_n);
        foreach (PBKDF2_TAG[i]) append_char(PBKDF2_TAG[i]);
        repeat (iters) append_char(rand_digit());
        append_char(phfc_pkg::CH_DOLLAR);
        repeat (salt_n) append_char(rand_hex());
        append_char(phfc_pkg::CH_DOLLAR);
        repeat (digest_n) append_char(rand_hex());
    endfunction

    // one well-formed string of either form with random content
    function automatic void put_random_form();
        int v;
        v = $urandom_range(2);
        if ($urandom_range(1) == 0) begin
            put_bcrypt(v == 0 ? phfc_pkg::CH_LOW_A
                              : (v == 1 ? phfc_pkg::CH_LOW_B : phfc_pkg::CH_LOW_Y), 53);
        end else if ($urandom_range(15) == 0) begin
            put_pbkdf2($urandom_range(140, 20), 32, 64);
        end else begin
            put_pbkdf2($urandom_range(6, 1), 32, 64);
        end
    endfunction

    // one random fault in the string being built
    function automatic void damage_text();
        int idx;
        int cut;
        idx = $urandom_range(text_q.size() - 1);
        case ($urandom_range(3))
            0: text_q[idx] = 8'($urandom_range(255));
            1: text_q.delete(idx);
            2: text_q.insert(idx, 8'($urandom_range(255)));
            default: begin
                cut = $urandom_range(text_q.size() - 1, 1);
                while (text_q.size() > cut) void'(text_q.pop_back());
            end
        endcase
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(input phfc_pkg::in_item_t it);
        phfc_pkg::out_item_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent_chars++;
        if (predict_verdict(it, res)) begin
            verdict_q = {verdict_q, res};
            sent_results++;
        end
    endtask

    task automatic send_text(input bit mark_end);
        phfc_pkg::in_item_t it;
        int                 n;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            it.char_code    = text_q[i];
            it.last_char    = mark_end && (i == n - 1);
            it.empty_string = 1'b0;
            send_item(it);
        end
        text_q.delete();
    endtask

    // empty-string item, the other fields are don't-care
    task automatic send_empty();
        phfc_pkg::in_item_t it;
        it.char_code    = 8'($urandom_range(255));
        it.last_char    = 1'($urandom_range(1));
        it.empty_string = 1'b1;
        send_item(it);
    endtask

    // stop offering and wait until every verdict is in
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // extremes of both forms and the named corner cases
    task automatic test_edge_cases();
        send_empty();
        put_bcrypt(phfc_pkg::CH_LOW_A, 53);
        text_q[4] = phfc_pkg::CH_ZERO;
        text_q[5] = phfc_pkg::CH_NINE;
        text_q[7] = phfc_pkg::CH_DOT;
        text_q[8] = phfc_pkg::CH_SLASH;
        text_q[9] = phfc_pkg::CH_UP_A;
        text_q[10] = phfc_pkg::CH_UP_Z;
        text_q[11] = phfc_pkg::CH_LOW_A;
        text_q[12] = phfc_pkg::CH_LOW_Z;
        text_q[13] = phfc_pkg::CH_ZERO;
        text_q[14] = phfc_pkg::CH_NINE;
        send_text(1'b1);
        // one short, one long
        put_bcrypt(phfc_pkg::CH_LOW_B, 52);
        send_text(1'b1);
        put_bcrypt(phfc_pkg::CH_LOW_Y, 54);
        send_text(1'b1);
        // bad variant letter 'c', bad cost digit, bad separator
        put_bcrypt(8'h63, 0);
        send_text(1'b1);
        put_bcrypt(phfc_pkg::CH_LOW_B, 0);
        text_q[4] = phfc_pkg::CH_LOW_A;
        send_text(1'b1);
        put_bcrypt(phfc_pkg::CH_LOW_Y, 0);
        text_q[6] = phfc_pkg::CH_DOT;
        send_text(1'b1);
        // non-ascii and nul bytes in the body
        put_bcrypt(phfc_pkg::CH_LOW_A, 1);
        text_q[7] = 8'hff;
        send_text(1'b1);
        put_bcrypt(phfc_pkg::CH_LOW_Y, 53);
        text_q[59] = 8'h80;
        send_text(1'b1);
        put_bcrypt(phfc_pkg::CH_LOW_A, 2);
        text_q[8] = 8'h00;
        send_text(1'b1);
        // pbkdf2 with hex extremes, then a long iteration count
        put_pbkdf2(1, 32, 64);
        text_q[9] = phfc_pkg::CH_ZERO;
        text_q[10] = phfc_pkg::CH_NINE;
        text_q[11] = phfc_pkg::CH_LOW_A;
        text_q[12] = phfc_pkg::CH_LOW_F;
        send_text(1'b1);
        put_pbkdf2(20, 32, 64);
        send_text(1'b1);
        // no iteration digits, short and long salt, long digest
        put_pbkdf2(0, 0, 0);
        send_text(1'b1);
        put_pbkdf2(3, 31, 0);
        send_text(1'b1);
        put_pbkdf2(3, 33, 0);
        send_text(1'b1);
        put_pbkdf2(3, 32, 65);
        send_text(1'b1);
        // upper-case hex in the salt, then a broken prefix ("pbkdg2")
        put_pbkdf2(2, 2, 0);
        text_q[10] = phfc_pkg::CH_UP_A;
        send_text(1'b1);
        put_pbkdf2(2, 0, 0);
        text_q[4] = 8'h67;
        send_text(1'b1);
        // single-character strings
        append_char(phfc_pkg::CH_DOLLAR);
        send_text(1'b1);
        append_char(phfc_pkg::CH_LOW_P);
        send_text(1'b1);
        append_char(8'hff);
        send_text(1'b1);
        // empty item part way through, then a good string
        put_bcrypt(phfc_pkg::CH_LOW_A, 0);
        while (text_q.size() > 5) void'(text_q.pop_back());
        send_text(1'b0);
        send_empty();
        put_bcrypt(phfc_pkg::CH_LOW_B, 53);
        send_text(1'b1);
        // wrong first character ('x'), failed phase held to the end
        put_bcrypt(phfc_pkg::CH_LOW_A, 0);
        text_q[0] = 8'h78;
        send_text(1'b1);
        wait_drain();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_stall();
        @(posedge aclk);
        stall_cycles = 300;
        repeat (12) begin
            append_char(8'($urandom_range(255)));
            send_text(1'b1);
        end
        put_pbkdf2(2, 0, 0);
        send_text(1'b1);
        wait_drain();
    endtask

    // mostly well-formed strings, some damaged, cut short or noise
    task automatic test_random_mix(input int char_goal);
        int first_chars;
        int pick;
        int cut;
        first_chars = sent_chars;
        while (sent_chars - first_chars < char_goal) begin
            pick = $urandom_range(99);
            if (pick >= 93) begin
                send_empty();
            end else if (pick >= 85) begin
                case ($urandom_range(2))
                    0: append_char(phfc_pkg::CH_DOLLAR);
                    1: append_char(phfc_pkg::CH_LOW_P);
                    default: append_char(8'($urandom_range(255)));
                endcase
                repeat ($urandom_range(7)) append_char(8'($urandom_range(255)));
                send_text(1'b1);
            end else begin
                put_random_form();
                if (pick >= 78) begin
                    cut = $urandom_range(text_q.size() - 1, 1);
                    while (text_q.size() > cut) void'(text_q.pop_back());
                    send_text(1'b0);
                    send_empty();
                end else begin
                    if (pick >= 55) damage_text();
                    send_text(1'b1);
                end
            end
        end
        wait_drain();
    endtask

    // result side: random or held-off ready
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_cycles > 0) begin
                m_ready <= 1'b0;
                stall_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // compare each accepted result with the oldest verdict
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual valid %0d kind %0d",
                         $time, m_data.hash_valid, m_data.format_kind);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_data.hash_valid !== want.hash_valid) begin
                    $display("%0t: hash_valid expected %0d actual %0d",
                             $time, want.hash_valid, m_data.hash_valid);
                    mismatch_count++;
                end
                if (m_data.format_kind !== want.format_kind) begin
                    $display("%0t: format_kind expected %0d actual %0d",
                             $time, want.format_kind, m_data.format_kind);
                    mismatch_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        mismatch_count = 0;
        sent_chars     = 0;
        sent_results   = 0;
        stall_cycles   = 0;
        send_idle_pct  = 30;
        recv_idle_pct  = 50;
        clear_scan();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_edge_cases();
        test_output_stall();
        test_random_mix(75);
        send_idle_pct = 50;
        recv_idle_pct = 30;
        test_random_mix(75);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(75);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/phfc_pkg.sv
rtl/core/password_hash_format_check.sv
tb/tb_password_hash_format_check.sv
